[src/gate_controller_obstacle_detect_assert.svh]
// Assertion macros used by the checker file of the gate controller.
`ifndef GATE_CONTROLLER_OBSTACLE_DETECT_ASSERT_SVH
`define GATE_CONTROLLER_OBSTACLE_DETECT_ASSERT_SVH

// Same-cycle implication, idle while reset is asserted.
`define GCOD_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("gcod check failed");

// Next-cycle implication, idle while reset is asserted.
`define GCOD_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("gcod check failed");

`endif

[src/gcod_pkg.sv]
package gcod_pkg;

    // Field widths
    localparam int TICKS_W = 22;
    localparam int POS_W   = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int STATE_W = 3;
    localparam int LED_W   = 2;
    localparam int REQ_W   = 2;

    // Conversion: ticks * 10625 / 1000000 == ticks * 17 / 1600
    // == floor(floor(ticks * 17 / 64) / 25); the last step by reciprocal
    localparam int PRE_W       = TICKS_W + 5;
    localparam int PRE_SHIFT   = 6;
    localparam int QUOT_IN_W   = PRE_W - PRE_SHIFT;
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP_25 = 22'd2684355;

    // Gate state codes
    localparam logic [STATE_W-1:0] ST_CHECK    = 3'd0;
    localparam logic [STATE_W-1:0] ST_OPENING  = 3'd1;
    localparam logic [STATE_W-1:0] ST_CLOSING  = 3'd2;
    localparam logic [STATE_W-1:0] ST_OPEN     = 3'd3;
    localparam logic [STATE_W-1:0] ST_CLOSED   = 3'd4;
    localparam logic [STATE_W-1:0] ST_OBSTACLE = 3'd5;

    // LED codes
    localparam logic [LED_W-1:0] LED_OFF   = 2'd0;
    localparam logic [LED_W-1:0] LED_GREEN = 2'd1;
    localparam logic [LED_W-1:0] LED_RED   = 2'd2;

    // Request flag codes
    localparam logic [REQ_W-1:0] REQ_NONE     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_OPEN     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_OBSTACLE = 2'd2;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_CLOSED_LIMIT  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_OPEN_LIMIT    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_OBSTACLE_JUMP = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] CLOSED_LIMIT_RST  = 16'd50;
    localparam logic [CFG_W-1:0] OPEN_LIMIT_RST    = 16'd270;
    localparam logic [CFG_W-1:0] OBSTACLE_JUMP_RST = 16'd20;

    // Result item, first field in the highest bits
    typedef struct packed {
        logic [POS_W-1:0]   displacement_mm;
        logic [POS_W-1:0]   position_mm;
        logic [LED_W-1:0]   led_colour;
        logic [STATE_W-1:0] next_gate_state;
        logic [STATE_W-1:0] acted_state;
    } gate_result_t;

endpackage

[src/gcod_mm_conv.sv]
module gcod_mm_conv
(
    input  logic [gcod_pkg::TICKS_W-1:0] echo_ticks,
    output logic [gcod_pkg::POS_W-1:0]   position_mm
);

    logic [gcod_pkg::PRE_W-1:0]                       scaled;
    logic [gcod_pkg::QUOT_IN_W-1:0]                   dividend;
    logic [gcod_pkg::QUOT_IN_W+gcod_pkg::RECIP_W-1:0] product;

    // Multiply by 17 as shift and add, then divide by 64
    assign scaled = {echo_ticks, 4'b0000}
                  + {{(gcod_pkg::PRE_W-gcod_pkg::TICKS_W){1'b0}}, echo_ticks};
    assign dividend = scaled[gcod_pkg::PRE_W-1:gcod_pkg::PRE_SHIFT];

    // Divide by 25 through the reciprocal; exact for the whole dividend range
    assign product = {{gcod_pkg::RECIP_W{1'b0}}, dividend}
                   * {{gcod_pkg::QUOT_IN_W{1'b0}}, gcod_pkg::RECIP_25};
    assign position_mm =
        product[gcod_pkg::RECIP_SHIFT+gcod_pkg::POS_W-1:gcod_pkg::RECIP_SHIFT];

endmodule

[src/gate_controller_obstacle_detect.sv]
// An accepted input item passes the input, position and result registers on its
// way to m_axis; these form a three-stage pipeline taking one item per clock
// while m_axis_tready lets it move, and a stage holds only while the next is full.
// The echo-to-millimetre multiply sits between the input and position stages.
// Reset (rst_n low, asynchronous): pipeline empty, gate in check, request
// flag open, previous position zero, LED off, limits 50, 270 and 20 mm.
module gate_controller_obstacle_detect
(
    input  logic        clk,
    input  logic        rst_n,
    // Input item
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // echo_ticks[21:0], presence_detect[22], zero[23]
    // Result item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // acted_state[2:0], next_gate_state[5:3],
                                        // led_colour[7:6], position_mm[23:8],
                                        // displacement_mm[39:24]
    // Register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [gcod_pkg::IDX_W-1:0] cfg_index,
    input  logic [gcod_pkg::CFG_W-1:0] cfg_data
);

    typedef enum logic [gcod_pkg::STATE_W-1:0] {
        S_CHECK    = gcod_pkg::ST_CHECK,
        S_OPENING  = gcod_pkg::ST_OPENING,
        S_CLOSING  = gcod_pkg::ST_CLOSING,
        S_OPEN     = gcod_pkg::ST_OPEN,
        S_CLOSED   = gcod_pkg::ST_CLOSED,
        S_OBSTACLE = gcod_pkg::ST_OBSTACLE
    } gate_state_t;

    // Configuration registers
    logic [gcod_pkg::CFG_W-1:0] closed_limit_reg;
    logic [gcod_pkg::CFG_W-1:0] open_limit_reg;
    logic [gcod_pkg::CFG_W-1:0] obstacle_jump_reg;

    // Pipeline
    logic                         in_valid_reg;
    logic [gcod_pkg::TICKS_W-1:0] in_ticks_reg;
    logic                         in_presence_reg;
    logic                         pos_valid_reg;
    logic [gcod_pkg::POS_W-1:0]   pos_mm_reg;
    logic                         pos_presence_reg;
    logic                         out_valid_reg;
    gcod_pkg::gate_result_t       result_reg;
    gcod_pkg::gate_result_t       result_next;

    // Gate machine state
    gate_state_t                  state_reg;
    gate_state_t                  state_next;
    logic [gcod_pkg::REQ_W-1:0]   req_reg;
    logic [gcod_pkg::REQ_W-1:0]   req_next;
    logic [gcod_pkg::POS_W-1:0]   prev_pos_reg;
    logic [gcod_pkg::LED_W-1:0]   led_reg;
    logic [gcod_pkg::LED_W-1:0]   led_next;

    logic                         conv_pos_mm;
    logic [gcod_pkg::POS_W-1:0]   conv_mm;
    logic [gcod_pkg::POS_W-1:0]   disp_mm;
    logic                         out_adv;
    logic                         pos_ready;
    logic                         out_load;

    // Stall control: each stage moves when the one after it has room
    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign pos_ready     = !pos_valid_reg || out_adv;
    assign s_axis_tready = !in_valid_reg || pos_ready;
    assign out_load      = pos_valid_reg && out_adv;
    assign conv_pos_mm   = in_valid_reg && pos_ready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result_reg;
    assign cfg_ready     = 1'b1;

    // Take register writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_limit_reg  <= gcod_pkg::CLOSED_LIMIT_RST;
            open_limit_reg    <= gcod_pkg::OPEN_LIMIT_RST;
            obstacle_jump_reg <= gcod_pkg::OBSTACLE_JUMP_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gcod_pkg::CFG_CLOSED_LIMIT:  closed_limit_reg  <= cfg_data;
                gcod_pkg::CFG_OPEN_LIMIT:    open_limit_reg    <= cfg_data;
                gcod_pkg::CFG_OBSTACLE_JUMP: obstacle_jump_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_ticks_reg    <= s_axis_tdata[gcod_pkg::TICKS_W-1:0];
            in_presence_reg <= s_axis_tdata[gcod_pkg::TICKS_W];
        end
    end

    // Convert echo width to millimetres
    gcod_mm_conv u_mm_conv
    (
        .echo_ticks  (in_ticks_reg),
        .position_mm (conv_mm)
    );

    // Position stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_valid_reg <= 1'b0;
        end
        else if (pos_ready)
        begin
            pos_valid_reg <= in_valid_reg;
        end
    end

    // Position stage payload
    always_ff @(posedge clk)
    begin
        if (conv_pos_mm)
        begin
            pos_mm_reg       <= conv_mm;
            pos_presence_reg <= in_presence_reg;
        end
    end

    // Absolute change from the previous position
    always_comb
    begin
        if (pos_mm_reg >= prev_pos_reg)
        begin
            disp_mm = pos_mm_reg - prev_pos_reg;
        end
        else
        begin
            disp_mm = prev_pos_reg - pos_mm_reg;
        end
    end

    // Step the gate machine on the item at the position stage
    always_comb
    begin
        state_next = S_CHECK;
        req_next   = req_reg;
        led_next   = led_reg;
        unique case (state_reg)
            S_OPENING:
            begin
                led_next = gcod_pkg::LED_GREEN;
            end
            S_OBSTACLE:
            begin
                led_next = gcod_pkg::LED_GREEN;
                req_next = gcod_pkg::REQ_OBSTACLE;
            end
            S_CLOSING:
            begin
                led_next = gcod_pkg::LED_RED;
                if ((pos_mm_reg > closed_limit_reg) && (disp_mm > obstacle_jump_reg))
                begin
                    state_next = S_OBSTACLE;
                end
            end
            S_CLOSED:
            begin
                state_next = S_CHECK;
            end
            S_OPEN:
            begin
                req_next = gcod_pkg::REQ_OPEN;
            end
            default:
            begin
                // Check: a pending obstacle reopens the gate regardless of presence
                if (req_reg == gcod_pkg::REQ_OBSTACLE)
                begin
                    state_next = (pos_mm_reg < open_limit_reg) ? S_OBSTACLE : S_OPEN;
                end
                else
                begin
                    req_next = {1'b0, pos_presence_reg};
                    if (pos_presence_reg)
                    begin
                        state_next = (pos_mm_reg < open_limit_reg) ? S_OPENING : S_OPEN;
                    end
                    else
                    begin
                        state_next = (pos_mm_reg > closed_limit_reg) ? S_CLOSING : S_CLOSED;
                    end
                end
            end
        endcase

        result_next.acted_state     = state_reg;
        result_next.next_gate_state = state_next;
        result_next.led_colour      = led_next;
        result_next.position_mm     = pos_mm_reg;
        result_next.displacement_mm = disp_mm;
    end

    // Hold machine state and the result item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CHECK;
            req_reg       <= gcod_pkg::REQ_OPEN;
            prev_pos_reg  <= '0;
            led_reg       <= gcod_pkg::LED_OFF;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            if (out_adv)
            begin
                out_valid_reg <= pos_valid_reg;
            end
            if (out_load)
            begin
                state_reg    <= state_next;
                req_reg      <= req_next;
                prev_pos_reg <= pos_mm_reg;
                led_reg      <= led_next;
                result_reg   <= result_next;
            end
        end
    end

endmodule

[src/gcod_checker.sv]
`include "gate_controller_obstacle_detect_assert.svh"

module gcod_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    gcod_pkg::gate_result_t res;
    logic                   out_stall;
    logic                   closing_out;
    logic                   green_out;
    logic                   leave_out;
    logic                   may_leave;

    assign res = m_axis_tdata;

    // Conditions seen on the result item
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign closing_out = m_axis_tvalid && (res.acted_state == gcod_pkg::ST_CLOSING);
    assign green_out   = m_axis_tvalid
                       && ((res.acted_state == gcod_pkg::ST_OPENING)
                           || (res.acted_state == gcod_pkg::ST_OBSTACLE));
    assign leave_out   = m_axis_tvalid && (res.next_gate_state != gcod_pkg::ST_CHECK);
    assign may_leave   = (res.acted_state == gcod_pkg::ST_CHECK)
                       || (res.acted_state == gcod_pkg::ST_CLOSING);

    // A stalled result item holds
    `GCOD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // Closing drives the LED red
    `GCOD_ASSERT_NOW(a_closing_red, clk, rst_n, closing_out, res.led_colour == gcod_pkg::LED_RED)

    // Opening and obstacle drive the LED green
    `GCOD_ASSERT_NOW(a_green, clk, rst_n, green_out, res.led_colour == gcod_pkg::LED_GREEN)

    // Only check and closing leave for anything but check
    `GCOD_ASSERT_NOW(a_return_check, clk, rst_n, leave_out, may_leave)

endmodule

bind gate_controller_obstacle_detect gcod_checker u_gcod_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[dv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gcod_pkg::*;

    // Echo width to millimetres: ticks * 10625 / 1000000
    localparam logic [63:0] MM_NUM = 64'd10625;
    localparam logic [63:0] MM_DEN = 64'd1000000;
    localparam int MAX_MM    = 44564;
    localparam int MAX_TICKS = 4194303;
    // Register index past the end of the list; writes to it are dropped
    localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;

    // Tracks the gate controller and holds the reports still to come
    class gate_tracker;
        logic [CFG_W-1:0]   closed_limit;
        logic [CFG_W-1:0]   open_limit;
        logic [CFG_W-1:0]   jump_limit;
        logic [STATE_W-1:0] gate_st;
        logic [REQ_W-1:0]   req;
        logic [POS_W-1:0]   last_pos;
        logic [LED_W-1:0]   led;
        gate_result_t       pending[$];
        int unsigned        mismatches;
        int unsigned        checked;
        int unsigned        obstacle_hits;

        function new();
            closed_limit  = CLOSED_LIMIT_RST;
            open_limit    = OPEN_LIMIT_RST;
            jump_limit    = OBSTACLE_JUMP_RST;
            gate_st       = ST_CHECK;
            req           = REQ_OPEN;
            last_pos      = '0;
            led           = LED_OFF;
            mismatches    = 0;
            checked       = 0;
            obstacle_hits = 0;
        endfunction

        function void set_limit(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_CLOSED_LIMIT:  closed_limit = value;
                CFG_OPEN_LIMIT:    open_limit   = value;
                CFG_OBSTACLE_JUMP: jump_limit   = value;
                default: ;
            endcase
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", msg);
        endfunction

        // Step the gate machine for one echo item and queue the report
        function void note_reading(logic [TICKS_W-1:0] ticks, logic presence);
            logic [63:0]        scaled;
            logic [POS_W-1:0]   pos;
            logic [POS_W-1:0]   disp;
            logic [STATE_W-1:0] acted;
            logic [STATE_W-1:0] nxt;
            gate_result_t       exp;
            scaled = (64'(ticks) * MM_NUM) / MM_DEN;
            pos    = scaled[POS_W-1:0];
            disp   = (pos >= last_pos) ? pos - last_pos : last_pos - pos;
            acted  = gate_st;
            nxt    = ST_CHECK;
            last_pos = pos;
            case (acted)
                ST_OPENING: led = LED_GREEN;
                ST_OBSTACLE:
                begin
                    led = LED_GREEN;
                    req = REQ_OBSTACLE;
                    obstacle_hits++;
                end
                ST_CLOSING:
                begin
                    led = LED_RED;
                    if (pos > closed_limit && disp > jump_limit)
                        nxt = ST_OBSTACLE;
                end
                ST_CLOSED: ;
                ST_OPEN: req = REQ_OPEN;
                default:
                begin
                    if (req == REQ_OBSTACLE)
                        nxt = (pos < open_limit) ? ST_OBSTACLE : ST_OPEN;
                    else
                    begin
                        req = presence ? REQ_OPEN : REQ_NONE;
                        if (presence)
                            nxt = (pos < open_limit) ? ST_OPENING : ST_OPEN;
                        else
                            nxt = (pos > closed_limit) ? ST_CLOSING : ST_CLOSED;
                    end
                end
            endcase
            gate_st = nxt;
            exp.acted_state     = acted;
            exp.next_gate_state = nxt;
            exp.led_colour      = led;
            exp.position_mm     = pos;
            exp.displacement_mm = disp;
            pending.push_back(exp);
        endfunction

        // Compare one report with the oldest one queued
        function void check_report(gate_result_t got);
            gate_result_t exp;
            if (pending.size() == 0)
            begin
                report($sformatf("report %h arrived with none outstanding", got));
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got.acted_state !== exp.acted_state
                || got.next_gate_state !== exp.next_gate_state
                || got.led_colour !== exp.led_colour
                || got.position_mm !== exp.position_mm
                || got.displacement_mm !== exp.displacement_mm)
                report($sformatf({"report %0d: exp acted %0d next %0d led %0d pos %0d ",
                    "disp %0d, got acted %0d next %0d led %0d pos %0d disp %0d"},
                    checked, exp.acted_state, exp.next_gate_state, exp.led_colour,
                    exp.position_mm, exp.displacement_mm, got.acted_state,
                    got.next_gate_state, got.led_colour, got.position_mm,
                    got.displacement_mm));
        endfunction
    endclass

    logic               clk;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [23:0]        s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [39:0]        m_axis_tdata;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_W-1:0]   cfg_data      = '0;

    gate_tracker tracker;
    int burst_left = 0;
    int last_mm    = 0;
    int cur_closed = int'(CLOSED_LIMIT_RST);
    int cur_open   = int'(OPEN_LIMIT_RST);
    int cur_jump   = int'(OBSTACLE_JUMP_RST);
    int rx_cycle   = 0;
    int rx_mode    = 0;
    int items_sent = 0;

    gate_controller_obstacle_detect i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Sample both handshakes and the register channel on the rising edge
    always @(posedge clk)
    begin
        if (rst_n && tracker != null)
        begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_report(gate_result_t'(m_axis_tdata));
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_reading(s_axis_tdata[TICKS_W-1:0], s_axis_tdata[TICKS_W]);
            if (cfg_valid && cfg_ready)
                tracker.set_limit(cfg_index, cfg_data);
        end
    end

    // Receiver back-pressure: a randomly chosen one of four ready patterns
    always @(negedge clk)
    begin
        if (rx_cycle % 150 == 0)
            rx_mode = $urandom_range(0, 3);
        rx_cycle++;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 9) < 3);
            default: m_axis_tready <= (rx_cycle % 5 != 0);
        endcase
    end

    // Smallest tick count that converts to mm, plus an offset within that mm
    function automatic logic [TICKS_W-1:0] ticks_for_mm(int mm, int jitter);
        longint t;
        t = (longint'(mm) * 1000000 + 10624) / 10625 + jitter;
        if (t > MAX_TICKS)
            t = MAX_TICKS;
        return t[TICKS_W-1:0];
    endfunction

    // Random echo aimed mostly at the thresholds and the obstacle jump
    function automatic logic [TICKS_W-1:0] pick_ticks();
        int mm;
        case ($urandom_range(0, 6))
            0: mm = cur_closed + int'($urandom_range(0, 6)) - 3;
            1: mm = cur_open + int'($urandom_range(0, 6)) - 3;
            2: mm = last_mm + cur_jump + int'($urandom_range(0, 4)) - 2;
            3: mm = last_mm - cur_jump + int'($urandom_range(0, 4)) - 2;
            4: mm = $urandom_range(0, 400);
            5: return TICKS_W'($urandom);
            default: mm = $urandom_range(0, MAX_MM);
        endcase
        if (mm < 0)
            mm = 0;
        if (mm > MAX_MM)
            mm = MAX_MM;
        return ticks_for_mm(mm, $urandom_range(0, 90));
    endfunction

    // Present one echo item, opening a gap between bursts
    task automatic send_echo(input logic [TICKS_W-1:0] ticks, input logic presence);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, presence, ticks};
        do @(posedge clk); while (!s_axis_tready);
        last_mm = int'((64'(ticks) * MM_NUM) / MM_DEN);
        items_sent++;
    endtask

    task automatic send_mm(input int mm, input logic presence);
        send_echo(ticks_for_mm(mm, 0), presence);
    endtask

    // Drop valid and wait until every report is back and the pipe is quiet
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(input int closed_l, input int open_l, input int jump_l,
                              input logic poke_spare);
        write_reg(CFG_CLOSED_LIMIT, CFG_W'(closed_l));
        write_reg(CFG_OPEN_LIMIT, CFG_W'(open_l));
        write_reg(CFG_OBSTACLE_JUMP, CFG_W'(jump_l));
        if (poke_spare)
            write_reg(CFG_SPARE, CFG_W'($urandom));
        cur_closed = closed_l;
        cur_open   = open_l;
        cur_jump   = jump_l;
    endtask

    task automatic random_echoes(input int count);
        repeat (count) send_echo(pick_ticks(), $urandom_range(0, 1));
    endtask

    initial
    begin
        int settings;
        int c_lim;
        tracker = new();
        settings = 1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk every state at the reset limits (closed 50, open 270, jump 20)
        send_mm(0, 1'b1);                       // check with request -> opening
        send_echo(TICKS_W'(MAX_TICKS), 1'b0);   // opening, green; top of range
        send_mm(270, 1'b1);                     // request at open limit -> open
        send_mm(269, 1'b0);                     // open re-arms request
        send_mm(51, 1'b0);                      // no request above closed -> closing
        send_mm(71, 1'b0);                      // jump equal to limit, no obstacle
        send_mm(50, 1'b0);                      // at closed limit -> closed
        send_mm(50, 1'b1);
        send_mm(269, 1'b1);                     // just under open limit -> opening
        send_mm(400, 1'b0);
        send_mm(300, 1'b0);                     // -> closing
        send_mm(51, 1'b1);                      // large jump while closing -> obstacle
        send_mm(60, 1'b0);                      // obstacle latches the pending flag
        send_mm(269, 1'b0);                     // pending, below open -> obstacle again
        send_mm(270, 1'b1);
        send_mm(270, 1'b0);                     // pending, at open limit -> open
        send_mm(0, 1'b0);
        send_mm(100, 1'b0);                     // -> closing
        send_mm(50, 1'b0);                      // jump but at closed limit -> check
        send_echo(TICKS_W'(MAX_TICKS), 1'b0);   // -> closing from far away
        send_mm(0, 1'b1);                       // closing, position low -> check
        send_echo(22'h2AAAAA, 1'b1);
        send_echo(22'h155555, 1'b0);
        random_echoes(280);
        drain();

        // Extreme and random limit settings
        set_limits(0, 0, 0, 1'b0);
        random_echoes(240);
        drain();
        set_limits(65535, 65535, 65535, 1'b1);
        random_echoes(240);
        drain();
        set_limits(0, 65535, 0, 1'b0);
        random_echoes(240);
        drain();
        set_limits(65535, 0, 65535, 1'b1);
        random_echoes(240);
        drain();
        c_lim = $urandom_range(0, 300);
        set_limits(c_lim, c_lim + $urandom_range(0, 500), $urandom_range(0, 60), 1'b1);
        random_echoes(240);
        drain();
        settings = 6;

        if (tracker.pending.size() != 0)
            tracker.report("reports still outstanding at end of run");
        $display("Sent %0d echo items over %0d limit settings; %0d reports checked.",
                 items_sent, settings, tracker.checked);
        $display("Obstacle state handled %0d times; %0d mismatches.",
                 tracker.obstacle_hits, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/gcod_pkg.sv
src/gcod_mm_conv.sv
src/gate_controller_obstacle_detect.sv
src/gcod_checker.sv
dv/tb.sv
